/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helper macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked every clock, suspended while reset is high.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, suspended while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/bfa_pkg.sv */
// ----------------------------------------------------------------------------
// bfa_pkg
// Types and constants shared by the bitmap fit allocator and its checker.
// ----------------------------------------------------------------------------
package bfa_pkg;

  localparam int Clusters = 1024;
  localparam int IdxW     = $clog2(Clusters);
  localparam int CntW     = IdxW + 1;
  localparam int WordW    = 16;
  localparam int Words    = Clusters / WordW;
  localparam int WordAw   = $clog2(Words);
  localparam int BitAw    = $clog2(WordW);

  localparam logic [0:0] ACT_ALLOC   = 1'b0;
  localparam logic [0:0] ACT_RELEASE = 1'b1;

  localparam logic [1:0] ALG_FIRST = 2'd0;
  localparam logic [1:0] ALG_BEST  = 2'd1;
  localparam logic [1:0] ALG_WORST = 2'd2;
  localparam logic [1:0] ALG_NONE  = 2'd3;  // unknown algorithm code

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOSPACE  = 2'd1;
  localparam logic [1:0] ST_NOFIT    = 2'd2;
  localparam logic [1:0] ST_BADRANGE = 2'd3;

  typedef struct packed {
    logic [0:0]      action;
    logic [1:0]      algorithm;
    logic [CntW-1:0] cluster_count;
    logic [IdxW-1:0] start_index;
  } req_t;

  typedef struct packed {
    logic [1:0]      status;
    logic [IdxW-1:0] granted_start;
    logic [CntW-1:0] granted_count;
    logic [CntW-1:0] free_count;
  } rsp_t;

endpackage

/* rtl/bitmap_fit_allocator_unit.sv */
// ----------------------------------------------------------------------------
// bitmap_fit_allocator_unit
// Cluster allocator over a 1-bit-per-cluster free map (first/best/worst fit).
// ----------------------------------------------------------------------------
// Operation: an allocate scans one map bit a cycle from start_index towards the
//   end (first fit stops at its first fitting run), then marks N bits. A release
//   marks N bits; a request rejected up front, or a search that finds no run,
//   responds without marking.
// One transaction at a time; the next is taken after the response is accepted.
// Reset: synchronous; a clear pass (one word a cycle) frees the map.
module bitmap_fit_allocator_unit (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  bfa_pkg::req_t  req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output bfa_pkg::rsp_t  rsp
);

  localparam int IdxW   = bfa_pkg::IdxW;
  localparam int CntW   = bfa_pkg::CntW;
  localparam int WordAw = bfa_pkg::WordAw;
  localparam int BitAw  = bfa_pkg::BitAw;

  // Sequencer states. Map reads are registered, so each scan/update step
  // issues an address and consumes the data in the next cycle (pipelined).
  typedef enum logic [6:0] {
    S_CLEAR  = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_CHECK  = 7'b0000100,
    S_SCAN   = 7'b0001000,
    S_MARK   = 7'b0010000,
    S_MARKWB = 7'b0100000,
    S_RESP   = 7'b1000000
  } state_t;

  state_t state;

  // Free-map memory: 16-bit words, one read and one write port.
  logic [bfa_pkg::WordW-1:0] fmap [bfa_pkg::Words];
  logic [bfa_pkg::WordW-1:0] rd_word;
  logic [WordAw-1:0]         rd_addr;
  logic                      wr_en;
  logic [WordAw-1:0]         wr_addr;
  logic [bfa_pkg::WordW-1:0] wr_word;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      fmap[wr_addr] <= wr_word;
    end
    rd_word <= fmap[rd_addr];
  end

  bfa_pkg::req_t   cur;
  logic [CntW-1:0] free_total;
  logic [CntW-1:0] pos;        // bit being fetched (may go past Clusters)
  logic [CntW-1:0] pos_d;      // bit whose data is in rd_word
  logic            data_ok;    // rd_word holds pos_d
  logic [CntW-1:0] run_start, run_len;
  logic            have;
  logic [IdxW-1:0] best_start;
  logic [CntW-1:0] best_len;
  logic [CntW-1:0] left;       // clusters still to mark
  logic [CntW-1:0] delta;      // map changes so far in this update
  logic [bfa_pkg::WordW-1:0] wb_word;
  logic [WordAw-1:0]         wb_addr;
  logic            wb_pend;
  logic [WordAw-1:0]         clr_addr;

  // Datapath helpers
  logic [CntW-1:0] end_sum;
  logic            cur_bit;
  logic [BitAw-1:0] bsel;
  logic            take;
  logic            alloc;
  logic            scan_done;

  assign alloc   = (cur.action == bfa_pkg::ACT_ALLOC);
  assign end_sum = CntW'(cur.start_index) + cur.cluster_count;
  assign bsel    = pos_d[BitAw-1:0];
  assign cur_bit = (pos_d < CntW'(bfa_pkg::Clusters)) ?
                   (wb_pend && wb_addr == pos_d[IdxW-1:BitAw] ? wb_word[bsel]
                                                              : rd_word[bsel])
                   : 1'b0;

  always_comb begin
    take = 1'b0;
    if (run_len >= cur.cluster_count && run_len != '0) begin
      if (!have) begin
        take = 1'b1;
      end else begin
        case (cur.algorithm)
          bfa_pkg::ALG_BEST:  take = run_len < best_len;
          bfa_pkg::ALG_WORST: take = run_len > best_len;
          default:            take = 1'b0;
        endcase
      end
    end
  end

  // A used cluster (or the end of the map) closes the current run; the scan
  // stops there on a first-fit hit or at the end of the map.
  assign scan_done = data_ok && !cur_bit &&
                     ((take && cur.algorithm == bfa_pkg::ALG_FIRST) ||
                      pos_d == CntW'(bfa_pkg::Clusters));

  assign req_ready = (state == S_IDLE);
  assign rd_addr   = pos[IdxW-1:BitAw];

  logic [1:0]      r_status;
  logic [IdxW-1:0] r_start;
  logic [CntW-1:0] r_count;

  assign rsp.status        = r_status;
  assign rsp.granted_start = r_start;
  assign rsp.granted_count = r_count;
  assign rsp.free_count    = free_total;
  assign rsp_valid         = (state == S_RESP);

  // Write port: clear sweep, or read-modify-write of the current word.
  logic [bfa_pkg::WordW-1:0] mod_word;
  always_comb begin
    mod_word = (wb_pend && wb_addr == pos_d[IdxW-1:BitAw]) ? wb_word : rd_word;
    mod_word[bsel] = !alloc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      free_total <= CntW'(bfa_pkg::Clusters);
      wb_pend    <= 1'b0;
      data_ok    <= 1'b0;
      wr_en      <= 1'b0;
    end else begin
      case (state)
        S_CLEAR: begin
          wr_en    <= 1'b1;
          wr_addr  <= clr_addr;
          wr_word  <= '1;
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == WordAw'(bfa_pkg::Words - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          wr_en <= 1'b0;
          if (req_valid) begin
            cur   <= req;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          wr_en      <= 1'b0;
          have       <= 1'b0;
          best_start <= '0;
          best_len   <= '0;
          run_len    <= '0;
          run_start  <= '0;
          delta      <= '0;
          wb_pend    <= 1'b0;
          data_ok    <= 1'b0;
          pos        <= CntW'(cur.start_index);
          if (alloc) begin
            r_start <= '0;
            r_count <= '0;
            if (cur.cluster_count == '0 || cur.algorithm == bfa_pkg::ALG_NONE) begin
              r_status <= bfa_pkg::ST_NOFIT;
              state    <= S_RESP;
            end else if (free_total < cur.cluster_count) begin
              r_status <= bfa_pkg::ST_NOSPACE;
              state    <= S_RESP;
            end else begin
              r_status <= bfa_pkg::ST_OK;
              state    <= S_SCAN;
            end
          end else begin
            if (cur.cluster_count == '0 ||
                end_sum > CntW'(bfa_pkg::Clusters) ||
                end_sum < cur.cluster_count) begin
              r_status <= bfa_pkg::ST_BADRANGE;
              r_start  <= '0;
              r_count  <= '0;
              state    <= S_RESP;
            end else begin
              r_status  <= bfa_pkg::ST_OK;
              r_start   <= cur.start_index;
              r_count   <= cur.cluster_count;
              left      <= cur.cluster_count;
              state     <= S_MARK;
            end
          end
        end
        S_SCAN: begin
          // pos fetches; pos_d evaluates the bit that pos fetched in the previous cycle.
          wr_en <= 1'b0;
          pos_d <= pos;
          if (scan_done) begin
            data_ok <= 1'b0;
            if (have || take) begin
              pos     <= take ? run_start : CntW'(best_start);
              r_start <= take ? run_start[IdxW-1:0] : best_start;
              r_count <= cur.cluster_count;
              left    <= cur.cluster_count;
              state   <= S_MARK;
            end else begin
              r_status <= bfa_pkg::ST_NOFIT;
              state    <= S_RESP;
            end
          end else begin
            pos     <= pos + 1'b1;
            data_ok <= 1'b1;
            if (data_ok) begin
              if (cur_bit) begin
                if (run_len == '0) run_start <= pos_d;
                run_len <= run_len + 1'b1;
              end else begin
                if (take) begin
                  have       <= 1'b1;
                  best_start <= run_start[IdxW-1:0];
                  best_len   <= run_len;
                end
                run_len <= '0;
              end
            end
          end
        end
        S_MARK: begin
          // One cluster per cycle, read-modify-write through wb_word.
          pos     <= pos + 1'b1;
          pos_d   <= pos;
          data_ok <= (left != '0);
          if (left != '0) left <= left - 1'b1;
          if (data_ok) begin
            wb_pend <= 1'b1;
            wb_addr <= pos_d[IdxW-1:BitAw];
            wb_word <= mod_word;
            if (cur_bit == alloc) delta <= delta + 1'b1;
            // Word finished: flush it once the run moves into the next one.
            wr_en   <= wb_pend && wb_addr != pos_d[IdxW-1:BitAw];
            wr_addr <= wb_addr;
            wr_word <= wb_word;
          end else begin
            wr_en <= 1'b0;
            if (left == '0) state <= S_MARKWB;
          end
        end
        S_MARKWB: begin
          wr_en      <= wb_pend;
          wr_addr    <= wb_addr;
          wr_word    <= wb_word;
          wb_pend    <= 1'b0;
          free_total <= alloc ? free_total - delta : free_total + delta;
          state      <= S_RESP;
        end
        S_RESP: begin
          wr_en <= 1'b0;
          if (rsp_ready) state <= S_IDLE;
        end
        default: begin
          wr_en <= 1'b0;
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/bfa_checker.sv */
// ----------------------------------------------------------------------------
// bfa_checker
// Port-level checks for the bitmap fit allocator.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bfa_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_ready,
  input bfa_pkg::req_t req,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input bfa_pkg::rsp_t rsp
);

  localparam logic [bfa_pkg::CntW-1:0] FreeMax = bfa_pkg::CntW'(bfa_pkg::Clusters);

  logic fail_rsp;
  logic grant_zero;
  logic req_wait;
  logic rsp_wait;

  assign fail_rsp   = rsp_valid && (rsp.status != bfa_pkg::ST_OK);
  assign grant_zero = (rsp.granted_count == '0) && (rsp.granted_start == '0);
  assign req_wait   = req_valid && !req_ready;
  assign rsp_wait   = rsp_valid && !rsp_ready;

  `ASSERT_IMPLY(a_free_range, clk, rst, rsp_valid, rsp.free_count <= FreeMax, "free over range")
  `ASSERT_IMPLY(a_fail_zero, clk, rst, fail_rsp, grant_zero, "failure carries a grant")
  `ASSERT_NEXT(a_accept_busy, clk, rst, req_valid && req_ready, !req_ready, "ready after accept")
  `ASSERT_NEXT(a_req_hold, clk, rst, req_wait, req_valid && $stable(req), "request not held")
  `ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_wait, rsp_valid && $stable(rsp), "response not held")

endmodule

bind bitmap_fit_allocator_unit bfa_checker u_bfa_checker (.*);

/* verif/bitmap_fit_allocator_unit_tb.sv */
// ----------------------------------------------------------------------------
// bitmap_fit_allocator_unit_tb
// Drives allocate and release requests with random idling on both channels
// and checks each response against a behavioral free-map model in the bench.
// ----------------------------------------------------------------------------
module bitmap_fit_allocator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  bfa_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  bfa_pkg::rsp_t rsp;

  bitmap_fit_allocator_unit u_top (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Bench copy of the allocator state.
  bit   cluster_free [bfa_pkg::Clusters];
  int   free_clusters;
  bfa_pkg::rsp_t expected_rsp [$];

  int errors = 0;
  int n_sent = 0;
  int n_rsp = 0;
  int n_ok = 0;
  int n_fail = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    $display("mismatch @%0t rsp #%0d %s: got %0d want %0d", $time, n_rsp, what, got, want);
  endtask

  // Scan free runs from 'from' towards the end (first fit stops at its first fit); earliest run wins on ties.
  function automatic bit find_run(input int need, input int from, input logic [1:0] alg,
                                  output int found);
    bit have = 0;
    int best_len = 0;
    int run_start = 0;
    int run_len = 0;
    found = 0;
    for (int i = from; i <= bfa_pkg::Clusters; i++) begin
      if (i < bfa_pkg::Clusters && cluster_free[i]) begin
        if (run_len == 0) run_start = i;
        run_len++;
      end else begin
        if (run_len >= need) begin
          if (!have || (alg == bfa_pkg::ALG_BEST && run_len < best_len) ||
              (alg == bfa_pkg::ALG_WORST && run_len > best_len)) begin
            have = 1;
            found = run_start;
            best_len = run_len;
          end
          if (alg == bfa_pkg::ALG_FIRST) break;
        end
        run_len = 0;
      end
    end
    return have;
  endfunction

  // Apply one request to the bench state and return the response it must produce.
  function automatic bfa_pkg::rsp_t predict_allocation(input bfa_pkg::req_t r);
    bfa_pkg::rsp_t o;
    int cnt;
    int idx;
    int at;
    o = '0;
    cnt = int'(r.cluster_count);
    idx = int'(r.start_index);
    o.status = bfa_pkg::ST_OK;
    if (r.action == bfa_pkg::ACT_ALLOC) begin
      if (cnt == 0 || r.algorithm > bfa_pkg::ALG_WORST) o.status = bfa_pkg::ST_NOFIT;
      else if (free_clusters < cnt) o.status = bfa_pkg::ST_NOSPACE;
      else if (!find_run(cnt, idx, r.algorithm, at)) o.status = bfa_pkg::ST_NOFIT;
      else begin
        for (int k = at; k < at + cnt && k < bfa_pkg::Clusters; k++)
          if (cluster_free[k]) begin
            cluster_free[k] = 0;
            free_clusters--;
          end
        o.granted_start = bfa_pkg::IdxW'(at);
        o.granted_count = bfa_pkg::CntW'(cnt);
      end
    end else begin
      if (cnt == 0 || idx + cnt > bfa_pkg::Clusters) o.status = bfa_pkg::ST_BADRANGE;
      else begin
        for (int k = idx; k < idx + cnt; k++)
          if (!cluster_free[k]) begin
            cluster_free[k] = 1;
            free_clusters++;
          end
        o.granted_start = bfa_pkg::IdxW'(idx);
        o.granted_count = bfa_pkg::CntW'(cnt);
      end
    end
    o.free_count = bfa_pkg::CntW'(free_clusters);
    return o;
  endfunction

  // Send one transaction; expectation is queued when it is accepted.
  // Valid stays up after the accept unless the sender idles before the next one.
  task automatic send_request(input logic act, input logic [1:0] alg, input int cnt,
                              input int idx);
    bfa_pkg::req_t r;
    r.action = act;
    r.algorithm = alg;
    r.cluster_count = bfa_pkg::CntW'(cnt);
    r.start_index = bfa_pkg::IdxW'(idx);
    if ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    req_valid <= 1'b1;
    req <= r;
    do @(posedge clk); while (!req_ready);
    expected_rsp.push_back(predict_allocation(r));
    n_sent++;
  endtask

  // Response side: random stall, compare every accepted transaction.
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_valid && rsp_ready) begin
        n_rsp++;
        if (expected_rsp.size() == 0) begin
          report_mismatch("unexpected response", n_rsp, n_sent);
        end else begin
          bfa_pkg::rsp_t w;
          w = expected_rsp.pop_front();
          if (rsp.status != w.status)
            report_mismatch("status", int'(rsp.status), int'(w.status));
          if (rsp.granted_start != w.granted_start)
            report_mismatch("granted_start", int'(rsp.granted_start), int'(w.granted_start));
          if (rsp.granted_count != w.granted_count)
            report_mismatch("granted_count", int'(rsp.granted_count), int'(w.granted_count));
          if (rsp.free_count != w.free_count)
            report_mismatch("free_count", int'(rsp.free_count), int'(w.free_count));
          if (w.status == bfa_pkg::ST_OK) n_ok++;
          else n_fail++;
        end
      end
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic wait_drained();
    req_valid <= 1'b0;
    while (expected_rsp.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Extremes, every algorithm and each rejection path.
  task automatic test_directed();
    send_request(bfa_pkg::ACT_ALLOC, bfa_pkg::ALG_FIRST, 0, 0);      // zero-length allocate
    send_request(bfa_pkg::ACT_ALLOC, bfa_pkg::ALG_NONE, 4, 0);       // unknown algorithm
    send_request(bfa_pkg::ACT_ALLOC, bfa_pkg::ALG_FIRST, 1025, 0);   // more than exists
    send_request(bfa_pkg::ACT_ALLOC, bfa_pkg::ALG_FIRST, 1024, 0);   // whole map
    send_request(bfa_pkg::ACT_ALLOC, bfa_pkg::ALG_BEST, 1, 0);       // map full
    send_request(bfa_pkg::ACT_RELEASE, bfa_pkg::ALG_FIRST, 1024, 0); // free everything
    send_request(bfa_pkg::ACT_RELEASE, bfa_pkg::ALG_FIRST, 0, 5);    // zero-length release
    send_request(bfa_pkg::ACT_RELEASE, bfa_pkg::ALG_FIRST, 2, 1023); // runs past the end
    send_request(bfa_pkg::ACT_RELEASE, bfa_pkg::ALG_FIRST, 2047, 1023);
    send_request(bfa_pkg::ACT_RELEASE, bfa_pkg::ALG_FIRST, 1, 1023); // already free
    send_request(bfa_pkg::ACT_ALLOC, bfa_pkg::ALG_WORST, 1, 1023);   // last cluster
    send_request(bfa_pkg::ACT_ALLOC, bfa_pkg::ALG_FIRST, 1, 1023);   // no run at the tail
    // Holes of 3, 10 and 2 clusters, then compare the algorithms.
    send_request(bfa_pkg::ACT_ALLOC, bfa_pkg::ALG_FIRST, 1023, 0);
    send_request(bfa_pkg::ACT_RELEASE, bfa_pkg::ALG_FIRST, 3, 100);
    send_request(bfa_pkg::ACT_RELEASE, bfa_pkg::ALG_FIRST, 10, 300);
    send_request(bfa_pkg::ACT_RELEASE, bfa_pkg::ALG_FIRST, 2, 600);
    send_request(bfa_pkg::ACT_ALLOC, bfa_pkg::ALG_BEST, 2, 0);
    send_request(bfa_pkg::ACT_ALLOC, bfa_pkg::ALG_WORST, 2, 0);
    send_request(bfa_pkg::ACT_ALLOC, bfa_pkg::ALG_FIRST, 2, 0);
    send_request(bfa_pkg::ACT_ALLOC, bfa_pkg::ALG_FIRST, 2, 305);    // run cut at start
    send_request(bfa_pkg::ACT_ALLOC, bfa_pkg::ALG_BEST, 9, 0);       // more than is free
    send_request(bfa_pkg::ACT_RELEASE, bfa_pkg::ALG_FIRST, 1024, 0);
    wait_drained();
  endtask

  // Mostly small allocate/release traffic so the map fragments; few large.
  task automatic test_random(input int n);
    int cnt;
    int idx;
    logic act;
    logic [1:0] alg;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(19))
        0: cnt = int'($urandom_range(2047));
        1, 2: cnt = int'($urandom_range(300, 1));
        default: cnt = int'($urandom_range(24, 1));
      endcase
      act = ($urandom_range(99) < 45);
      alg = ($urandom_range(3) == 3) ? bfa_pkg::ALG_NONE : 2'($urandom_range(2));
      idx = ($urandom_range(3) == 0) ? int'($urandom_range(1023, 900))
                                     : int'($urandom_range(1023));
      send_request(act, alg, cnt, idx);
      if ($urandom_range(199) == 0)
        send_request(bfa_pkg::ACT_RELEASE, bfa_pkg::ALG_FIRST, 1024, 0);
    end
  endtask

  initial begin
    for (int i = 0; i < bfa_pkg::Clusters; i++) cluster_free[i] = 1;
    free_clusters = bfa_pkg::Clusters;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 7;
    recv_stall_pct = 58;
    test_directed();
    test_random(640);
    send_idle_pct = 58;
    recv_stall_pct = 7;
    test_random(640);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_random(640);
    wait_drained();
    $display("covered %0d requests: %0d granted, %0d rejected", n_sent, n_ok, n_fail);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  // The whole run needs at most about 45 ms.
  initial begin
    #250ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
